// File: rtl/pfc_pkg.sv
// Package for the pixel format converter: format codes, register indexes,
// field widths and the per-format packing and gray weighting functions.
// Depends on nothing; used by pixel_format_converter.
package pfc_pkg;

  // Payload and configuration widths
  localparam int unsigned PixelW   = 24;
  localparam int unsigned FmtW     = 3;
  localparam int unsigned DepthW   = 4;
  localparam int unsigned CfgDataW = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned SumW     = 15;
  localparam int unsigned GrayW    = 8;

  // Pixel format codes; the code above RGB888 is unused
  typedef enum logic [FmtW-1:0] {
    FMT_GRAY8  = 3'd0,
    FMT_RGB332 = 3'd1,
    FMT_RGB444 = 3'd2,
    FMT_RGB555 = 3'd3,
    FMT_RGB565 = 3'd4,
    FMT_RGB666 = 3'd5,
    FMT_RGB888 = 3'd6
  } fmt_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SOURCE_FORMAT = 2'd0,
    REG_TARGET_FORMAT = 2'd1,
    REG_GRAY_DEPTH    = 2'd2
  } reg_idx_e;

  // Reset values of the configuration registers
  localparam logic [FmtW-1:0]   SourceFormatRst = FMT_RGB888;
  localparam logic [FmtW-1:0]   TargetFormatRst = FMT_RGB565;
  localparam logic [DepthW-1:0] GrayDepthRst    = 4'd8;

  // True for a format code that names a real format.
  function automatic logic fmt_valid(logic [FmtW-1:0] code);
    return code <= FMT_RGB888;
  endfunction

  // Keeps only the bits that belong to a pixel of the given format.
  function automatic logic [PixelW-1:0] pass_mask(fmt_e fmt, logic [PixelW-1:0] p);
    logic [PixelW-1:0] res;
    unique case (fmt)
      FMT_GRAY8,
      FMT_RGB332: res = {16'b0, p[7:0]};
      FMT_RGB444: res = {12'b0, p[11:0]};
      FMT_RGB555: res = {9'b0, p[14:0]};
      FMT_RGB565: res = {8'b0, p[15:0]};
      FMT_RGB666: res = {6'b0, p[17:0]};
      default:    res = p;
    endcase
    return res;
  endfunction

  // Truncates an RGB888 pixel to the field widths of the given format.
  function automatic logic [PixelW-1:0] pack_from_888(fmt_e fmt, logic [PixelW-1:0] p);
    logic [7:0]        r;
    logic [7:0]        g;
    logic [7:0]        b;
    logic [PixelW-1:0] res;
    r = p[23:16];
    g = p[15:8];
    b = p[7:0];
    unique case (fmt)
      FMT_RGB332: res = {16'b0, r[7:5], g[7:5], b[7:6]};
      FMT_RGB444: res = {12'b0, r[7:4], g[7:4], b[7:4]};
      FMT_RGB555: res = {9'b0, r[7:3], g[7:3], b[7:3]};
      FMT_RGB565: res = {8'b0, r[7:3], g[7:2], b[7:3]};
      FMT_RGB666: res = {6'b0, r[7:2], g[7:2], b[7:2]};
      default:    res = p;
    endcase
    return res;
  endfunction

  // Bits of precision of the gray value produced from each source format.
  function automatic logic [DepthW-1:0] gray_bits(fmt_e fmt);
    logic [DepthW-1:0] res;
    unique case (fmt)
      FMT_RGB332: res = 4'd3;
      FMT_RGB444: res = 4'd4;
      FMT_RGB555: res = 4'd5;
      FMT_RGB565,
      FMT_RGB666: res = 4'd6;
      default:    res = 4'd8;
    endcase
    return res;
  endfunction

  // Weighted sum of the three fields, scaled down by 128. The low field takes
  // the smallest weight; formats whose low field is narrow double it.
  function automatic logic [GrayW-1:0] gray_value(fmt_e fmt, logic [PixelW-1:0] p);
    logic [SumW-1:0] sum;
    unique case (fmt)
      FMT_RGB332: sum = SumW'(p[1:0]) * 15'd28 + SumW'(p[4:2]) * 15'd76
                      + SumW'(p[7:5]) * 15'd38 + 15'd1;
      FMT_RGB444: sum = SumW'(p[3:0]) * 15'd14 + SumW'(p[7:4]) * 15'd76
                      + SumW'(p[11:8]) * 15'd38;
      FMT_RGB555: sum = SumW'(p[4:0]) * 15'd14 + SumW'(p[9:5]) * 15'd76
                      + SumW'(p[14:10]) * 15'd38;
      FMT_RGB565: sum = SumW'(p[4:0]) * 15'd28 + SumW'(p[10:5]) * 15'd76
                      + SumW'(p[15:11]) * 15'd76 + 15'd1;
      FMT_RGB666: sum = SumW'(p[5:0]) * 15'd14 + SumW'(p[11:6]) * 15'd76
                      + SumW'(p[17:12]) * 15'd38 + 15'd1;
      FMT_RGB888: sum = SumW'(p[7:0]) * 15'd14 + SumW'(p[15:8]) * 15'd76
                      + SumW'(p[23:16]) * 15'd38 + 15'd1;
      default:    sum = {p[7:0], 7'b0};
    endcase
    return sum[SumW-1:7];
  endfunction

endpackage

// File: rtl/pixel_format_converter.sv
// Pixel format converter top level: input register, conversion logic and
// result register on a streaming interface, plus three configuration registers.
// Depends on pfc_pkg.

// The block converts one packed pixel per beat and takes a new beat every
// clock cycle while the output side keeps up. Each pixel passes an input
// register and a result register. The result beat is presented from the result
// register once its pixel has passed the input register. There is no state
// between pixels. A colour target accepts only its own format (passed through,
// masked to the format's width) or RGB888 (truncated and repacked); any other
// pairing, or an unused format code, gives a zero pixel with the error flag in
// tuser. A grayscale target (target format 0) weights the source fields (a gray
// source is passed through) and shifts the gray value to gray_depth bits.
// Configuration must only be written while no beat is in flight.
module pixel_format_converter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [pfc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pfc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pfc_pkg::PixelW-1:0]     s_axis_tdata,  // [23:0] pixel_word
  // Output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [pfc_pkg::PixelW-1:0]     m_axis_tdata,  // [23:0] pixel_out
  output logic                           m_axis_tuser   // [0] format_error
);

  // Configuration registers
  logic [pfc_pkg::FmtW-1:0]   src_fmt_q;
  logic [pfc_pkg::FmtW-1:0]   dst_fmt_q;
  logic [pfc_pkg::DepthW-1:0] depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_fmt_q <= pfc_pkg::SourceFormatRst;
      dst_fmt_q <= pfc_pkg::TargetFormatRst;
      depth_q   <= pfc_pkg::GrayDepthRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pfc_pkg::REG_SOURCE_FORMAT: src_fmt_q <= cfg_wdata_i[pfc_pkg::FmtW-1:0];
        pfc_pkg::REG_TARGET_FORMAT: dst_fmt_q <= cfg_wdata_i[pfc_pkg::FmtW-1:0];
        pfc_pkg::REG_GRAY_DEPTH:    depth_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline handshake: each stage advances when its successor is free
  logic in_valid_q;
  logic out_valid_q;
  logic out_free;
  logic in_free;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign in_free       = !in_valid_q || out_free;
  assign s_axis_tready = in_free;

  // Input register
  logic [pfc_pkg::PixelW-1:0] pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_free) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && s_axis_tvalid) begin
      pix_q <= s_axis_tdata;
    end
  end

  // Conversion of the registered pixel
  pfc_pkg::fmt_e                src_fmt;
  pfc_pkg::fmt_e                dst_fmt;
  logic [pfc_pkg::GrayW-1:0]    gray;
  logic [pfc_pkg::DepthW-1:0]   gbits;
  logic [pfc_pkg::PixelW-1:0]   res_d;
  logic                         err_d;

  assign src_fmt = pfc_pkg::fmt_e'(src_fmt_q);
  assign dst_fmt = pfc_pkg::fmt_e'(dst_fmt_q);
  assign gray    = pfc_pkg::gray_value(src_fmt, pix_q);
  assign gbits   = pfc_pkg::gray_bits(src_fmt);

  always_comb begin
    res_d = '0;
    err_d = 1'b0;
    if (!pfc_pkg::fmt_valid(src_fmt_q) || !pfc_pkg::fmt_valid(dst_fmt_q)) begin
      err_d = 1'b1;
    end else if (dst_fmt != pfc_pkg::FMT_GRAY8) begin
      if (dst_fmt == src_fmt) begin
        res_d = pfc_pkg::pass_mask(src_fmt, pix_q);
      end else if (src_fmt == pfc_pkg::FMT_RGB888) begin
        res_d = pfc_pkg::pack_from_888(dst_fmt, pix_q);
      end else begin
        err_d = 1'b1;
      end
    end else if (gbits > depth_q) begin
      // Source is finer than the display: drop low bits
      res_d = {16'b0, gray} >> (gbits - depth_q);
    end else begin
      // Display is at least as fine: scale up
      res_d = {16'b0, gray} << (depth_q - gbits);
    end
  end

  // Result register
  logic [pfc_pkg::PixelW-1:0] res_q;
  logic                       err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && in_valid_q) begin
      res_q <= res_d;
      err_q <= err_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = err_q;

  // A refused conversion always carries a zero pixel.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && err_q |-> res_q == '0)
    else $error("format error beat with non-zero pixel");

  // An empty input stage never stalls the source.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stage empty but not ready");

  // A pixel that leaves the input stage lands in the result register.
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_free |=> out_valid_q)
    else $error("pixel lost between stages");

endmodule
